// ===== hw/rtl/ascii_left_to_right_calculator_defines.svh =====
`ifndef ASCII_LEFT_TO_RIGHT_CALCULATOR_DEFINES_SVH
`define ASCII_LEFT_TO_RIGHT_CALCULATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ALRC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ALRC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/alrc_pkg.sv =====
package alrc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;
    localparam int OPND_W        = 32;
    localparam int VALUE_W       = 48;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Bit positions in the error flag register.
    localparam int FLAG_DIV0 = 0;
    localparam int FLAG_SAT  = 1;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_NONE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } t_out_item;

    // Start command to a bit-serial unit; neg is the sign of the accumulator.
    typedef struct packed {
        logic start;
        logic neg;
    } t_unit_ctl;

    // Unit status: done pulses for one cycle while the result is steady.
    typedef struct packed {
        logic done;
        logic sat;
    } t_unit_sts;

    function automatic t_op decode_op(input logic [7:0] ch);
        t_op op;
        unique case (ch)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// ===== hw/rtl/alrc_mul_serial.sv =====
module alrc_mul_serial #(
    parameter int ACC_WIDTH = alrc_pkg::ACC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  alrc_pkg::t_unit_ctl         i_ctl,
    input  logic [ACC_WIDTH-1:0]        i_mag,
    input  logic [alrc_pkg::OPND_W-1:0] i_opnd,
    output alrc_pkg::t_unit_sts         o_sts,
    output logic [ACC_WIDTH-1:0]        o_result
);
    import alrc_pkg::*;

    localparam int CNT_W  = $clog2(OPND_W + 1);
    localparam int PROD_W = ACC_WIDTH + OPND_W;

    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic                 r_neg;
    logic [ACC_WIDTH-1:0] r_mag;
    logic [ACC_WIDTH-1:0] r_hi;
    logic [OPND_W-1:0]    r_lo;

    logic [ACC_WIDTH:0]   w_sum;
    logic [PROD_W-1:0]    w_prod;
    logic [OPND_W:0]      w_upper;
    logic                 w_fits;
    logic [ACC_WIDTH-1:0] w_low;
    logic [ACC_WIDTH-1:0] w_max;
    logic [ACC_WIDTH-1:0] w_min;

    // One multiplier bit per cycle, least significant first; the low half
    // of the product shifts in where the multiplier bits shift out.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mag} : '0);

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_cnt = CNT_W'(OPND_W);
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mag <= i_mag;
            r_neg <= i_ctl.neg;
            r_hi  <= '0;
            r_lo  <= i_opnd;
        end else if (r_cnt != '0) begin
            r_hi <= w_sum[ACC_WIDTH:1];
            r_lo <= {w_sum[0], r_lo[OPND_W-1:1]};
        end
    end

    // The magnitude fits if it stays below the half range; a negative
    // result may reach exactly the half range.
    assign w_prod  = {r_hi, r_lo};
    assign w_upper = w_prod[PROD_W-1:ACC_WIDTH-1];
    assign w_fits  = (w_upper == '0) ||
                     (r_neg && (w_upper == (OPND_W + 1)'(1)) &&
                      (w_prod[ACC_WIDTH-2:0] == '0));
    assign w_low   = w_prod[ACC_WIDTH-1:0];
    assign w_max   = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    assign w_min   = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

    always_comb begin
        if (!w_fits) begin
            o_result = r_neg ? w_min : w_max;
        end else begin
            o_result = r_neg ? (~w_low + 1'b1) : w_low;
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.sat  = !w_fits;

endmodule

// ===== hw/rtl/alrc_div_serial.sv =====
module alrc_div_serial #(
    parameter int ACC_WIDTH = alrc_pkg::ACC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  alrc_pkg::t_unit_ctl         i_ctl,
    input  logic [ACC_WIDTH-1:0]        i_mag,
    input  logic [alrc_pkg::OPND_W-1:0] i_opnd,
    output alrc_pkg::t_unit_sts         o_sts,
    output logic [ACC_WIDTH-1:0]        o_result
);
    import alrc_pkg::*;

    localparam int CNT_W = $clog2(ACC_WIDTH + 1);

    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic                 r_neg;
    logic [OPND_W-1:0]    r_rem;
    logic [OPND_W-1:0]    r_dvs;
    logic [ACC_WIDTH-1:0] r_quo;

    logic [OPND_W:0]      w_shift;
    logic [OPND_W+1:0]    w_diff;
    logic                 w_ge;

    // Restoring division, one quotient bit per cycle. The dividend leaves
    // r_quo at the top while quotient bits enter at the bottom.
    assign w_shift = {r_rem, r_quo[ACC_WIDTH-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = !w_diff[OPND_W+1];

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_cnt = CNT_W'(ACC_WIDTH);
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_neg <= i_ctl.neg;
            r_rem <= '0;
            r_dvs <= i_opnd;
            r_quo <= i_mag;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[OPND_W-1:0] : w_shift[OPND_W-1:0];
            r_quo <= {r_quo[ACC_WIDTH-2:0], w_ge};
        end
    end

    // The quotient magnitude never exceeds the dividend, so it cannot
    // saturate; the sign is put back for rounding toward zero.
    assign o_result   = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_sts.done = r_done;
    assign o_sts.sat  = 1'b0;

endmodule

// ===== hw/rtl/ascii_left_to_right_calculator.sv =====
// Channel  Direction  Payload                        Transfer when
// in       input      i_in_data  (ch, last)          i_in_valid and not o_in_stall
// out      output     o_out_data (value, status)     o_out_valid and not i_out_stall
//
// A digit that is not the last character passes through EXEC and back to IDLE;
// an operator applying add, subtract or no-op passes through EXEC and APPLY. An
// applied multiply adds a wait in MUL for the bit-serial multiplier (one operand
// bit per cycle); an applied divide adds a wait in DIV for the bit-serial divider.
// A last character adds the DONE state to load the result.
// Reset is synchronous and active low and returns the evaluator to its start state.
// The input is taken while a result waits in the output register; only a later
// result waits for that register to drain.
`include "ascii_left_to_right_calculator_defines.svh"

module ascii_left_to_right_calculator #(
    parameter int FRAC_BITS = alrc_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = alrc_pkg::ACC_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  alrc_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output alrc_pkg::t_out_item o_out_data
);
    import alrc_pkg::*;

    // Add and subtract are evaluated exactly in a word wide enough for both
    // the accumulator and the scaled operand, then clamped.
    localparam int SUM_W = ((ACC_WIDTH > OPND_W + FRAC_BITS) ? ACC_WIDTH
                                                            : OPND_W + FRAC_BITS) + 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_APPLY = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [7:0]                  r_ch;
    logic                        r_last;
    logic signed [ACC_WIDTH-1:0] r_acc, n_acc;
    logic [OPND_W-1:0]           r_operand, n_operand;
    t_op                         r_op, n_op;
    logic [1:0]                  r_flags, n_flags;
    t_out_item                   r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_is_digit;
    logic [7:0]                  w_ch_off;
    logic [OPND_W+3:0]           w_op10;
    logic                        w_op_ovf;
    logic signed [ACC_WIDTH-1:0] w_acc_max;
    logic signed [ACC_WIDTH-1:0] w_acc_min;
    logic signed [SUM_W-1:0]     w_a_ext;
    logic signed [SUM_W-1:0]     w_nq;
    logic signed [SUM_W-1:0]     w_sum;
    logic                        w_over;
    logic                        w_under;
    logic                        w_acc_neg;
    logic                        w_acc_pos;
    logic [ACC_WIDTH-1:0]        w_mag;
    t_state                      w_end_state;

    t_unit_ctl                   w_mul_ctl;
    t_unit_ctl                   w_div_ctl;
    t_unit_sts                   w_mul_sts;
    t_unit_sts                   w_div_sts;
    logic [ACC_WIDTH-1:0]        w_mul_res;
    logic [ACC_WIDTH-1:0]        w_div_res;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Decimal operand: operand * 10 + digit is formed as (x << 3) + (x << 1) + d.
    // Any carry above the operand width means the operand saturates.
    assign w_is_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign w_ch_off   = r_ch - CH_ZERO;
    assign w_op10     = (OPND_W + 4)'({r_operand, 3'b000}) +
                        (OPND_W + 4)'({r_operand, 1'b0}) +
                        (OPND_W + 4)'(w_ch_off[3:0]);
    assign w_op_ovf   = |w_op10[OPND_W+3:OPND_W];

    assign w_acc_max = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    assign w_acc_min = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

    // The operand is an integer, so it enters the fixed-point sum shifted
    // up by the fraction width.
    assign w_a_ext = SUM_W'(r_acc);
    assign w_nq    = $signed(SUM_W'(r_operand) << FRAC_BITS);
    assign w_sum   = (r_op == OP_SUB) ? (w_a_ext - w_nq) : (w_a_ext + w_nq);
    assign w_over  = w_sum > SUM_W'(w_acc_max);
    assign w_under = w_sum < SUM_W'(w_acc_min);

    // The serial units work on the magnitude of the accumulator. The most
    // negative value has a magnitude that still fits as an unsigned word.
    assign w_acc_neg = r_acc[ACC_WIDTH-1];
    assign w_acc_pos = !w_acc_neg && (r_acc != '0);
    assign w_mag     = w_acc_neg ? $unsigned(~r_acc + 1'b1) : $unsigned(r_acc);

    assign w_end_state = r_last ? S_DONE : S_IDLE;

    assign w_mul_ctl.start = (r_state == S_APPLY) && (r_op == OP_MUL);
    assign w_mul_ctl.neg   = w_acc_neg;
    assign w_div_ctl.start = (r_state == S_APPLY) && (r_op == OP_DIV) && (r_operand != '0);
    assign w_div_ctl.neg   = w_acc_neg;

    alrc_mul_serial #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mul_ctl),
        .i_mag    (w_mag),
        .i_opnd   (r_operand),
        .o_sts    (w_mul_sts),
        .o_result (w_mul_res)
    );

    alrc_div_serial #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_div_ctl),
        .i_mag    (w_mag),
        .i_opnd   (r_operand),
        .o_sts    (w_div_sts),
        .o_result (w_div_res)
    );

    // Control sequence for one character: EXEC folds a digit into the
    // operand, APPLY carries out the pending operator (add, subtract, no-op
    // and divide by zero at once, multiply and divide through the serial
    // units), and DONE loads the result and restarts the expression.
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_operand   = r_operand;
        n_op        = r_op;
        n_flags     = r_flags;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_is_digit) begin
                    if (w_op_ovf) begin
                        n_operand          = '1;
                        n_flags[FLAG_SAT]  = 1'b1;
                    end else begin
                        n_operand = w_op10[OPND_W-1:0];
                    end
                    n_state = r_last ? S_APPLY : S_IDLE;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_operand = '0;
                if (!w_is_digit) begin
                    n_op = decode_op(r_ch);
                end
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        if (w_over) begin
                            n_acc             = w_acc_max;
                            n_flags[FLAG_SAT] = 1'b1;
                        end else if (w_under) begin
                            n_acc             = w_acc_min;
                            n_flags[FLAG_SAT] = 1'b1;
                        end else begin
                            n_acc = w_sum[ACC_WIDTH-1:0];
                        end
                        n_state = w_end_state;
                    end
                    OP_MUL: begin
                        n_state = S_MUL;
                    end
                    OP_DIV: begin
                        if (r_operand == '0) begin
                            // A zero accumulator stays zero; otherwise clamp by sign.
                            n_flags[FLAG_DIV0] = 1'b1;
                            if (w_acc_pos) begin
                                n_acc = w_acc_max;
                            end else if (w_acc_neg) begin
                                n_acc = w_acc_min;
                            end
                            n_state = w_end_state;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        // An unknown operator drops the operand and keeps the accumulator.
                        n_state = w_end_state;
                    end
                endcase
            end
            S_MUL: begin
                if (w_mul_sts.done) begin
                    n_acc = w_mul_res;
                    if (w_mul_sts.sat) begin
                        n_flags[FLAG_SAT] = 1'b1;
                    end
                    n_state = w_end_state;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_acc = w_div_res;
                    if (w_div_sts.sat) begin
                        n_flags[FLAG_SAT] = 1'b1;
                    end
                    n_state = w_end_state;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out.value = VALUE_W'(r_acc);
                    priority if (r_flags[FLAG_DIV0]) begin
                        n_out.status = ST_DIV0;
                    end else if (r_flags[FLAG_SAT]) begin
                        n_out.status = ST_SAT;
                    end else begin
                        n_out.status = ST_OK;
                    end
                    n_out_valid = 1'b1;
                    n_acc       = '0;
                    n_operand   = '0;
                    n_op        = OP_ADD;
                    n_flags     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_operand   <= '0;
            r_op        <= OP_ADD;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_operand   <= n_operand;
            r_op        <= n_op;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    // The character is held for the whole evaluation; a new one arrives
    // only once the sequence is back in IDLE.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_in_data.ch;
            r_last <= i_in_data.last;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ALRC_ASSERT_NEXT(a_accept_exec, w_accept, r_state == S_EXEC, "accepted character did not reach execution")
    `ALRC_ASSERT_NOW(a_mul_done_state, w_mul_sts.done, r_state == S_MUL, "multiplier finished outside its wait state")
    `ALRC_ASSERT_NOW(a_div_done_state, w_div_sts.done, r_state == S_DIV, "divider finished outside its wait state")
    `ALRC_ASSERT_NEXT(a_result_restart, (r_state == S_DONE) && w_out_free, r_out_valid && (r_acc == '0) && (r_flags == '0) && (r_op == OP_ADD), "result transfer did not restart the expression")
    `ALRC_ASSERT_NOW(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE), "result appeared without passing the done state")

endmodule
